// ===== rtl/cot_pkg.sv =====
// Shared constants, types and sign table for the clutched orientation tracker.
package cot_pkg;

  localparam int QUAT_WIDTH  = 16;
  localparam int STAMP_WIDTH = 32;
  localparam int WIN_WIDTH   = 16;
  localparam logic [WIN_WIDTH-1:0] WIN_RESET = 16'd300;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
  } mac_ctrl_t;

  // Hamilton product: component i, term k multiplies a[k] by b[i ^ k]
  function automatic logic term_neg(input logic [1:0] i, input logic [1:0] k);
    logic r;
    unique case (i)
      2'd0: r = (k != 2'd0);
      2'd1: r = (k == 2'd3);
      2'd2: r = (k == 2'd1);
      2'd3: r = (k == 2'd2);
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cot_frame_if.sv =====
// Input frame channel: button levels, timestamp and physical quaternion.
interface cot_frame_if #(
  parameter int QW = cot_pkg::QUAT_WIDTH,
  parameter int SW = cot_pkg::STAMP_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 left_pressed;
  logic                 right_pressed;
  logic        [SW-1:0] time_ms;
  logic signed [QW-1:0] phys_w;
  logic signed [QW-1:0] phys_x;
  logic signed [QW-1:0] phys_y;
  logic signed [QW-1:0] phys_z;

  modport source (output valid, left_pressed, right_pressed, time_ms,
                  phys_w, phys_x, phys_y, phys_z, input ready);
  modport sink   (input valid, left_pressed, right_pressed, time_ms,
                  phys_w, phys_x, phys_y, phys_z, output ready);
endinterface

// ===== rtl/cot_pose_if.sv =====
// Result channel: per-hand rest and aiming flags and virtual quaternion.
interface cot_pose_if #(
  parameter int QW = cot_pkg::QUAT_WIDTH
);
  logic                 valid;
  logic                 ready;
  logic                 left_at_rest;
  logic                 left_aiming;
  logic signed [QW-1:0] left_w;
  logic signed [QW-1:0] left_x;
  logic signed [QW-1:0] left_y;
  logic signed [QW-1:0] left_z;
  logic                 right_at_rest;
  logic                 right_aiming;
  logic signed [QW-1:0] right_w;
  logic signed [QW-1:0] right_x;
  logic signed [QW-1:0] right_y;
  logic signed [QW-1:0] right_z;

  modport source (output valid, left_at_rest, left_aiming, left_w, left_x, left_y, left_z,
                  right_at_rest, right_aiming, right_w, right_x, right_y, right_z,
                  input ready);
  modport sink   (input valid, left_at_rest, left_aiming, left_w, left_x, left_y, left_z,
                  right_at_rest, right_aiming, right_w, right_x, right_y, right_z,
                  output ready);
endinterface

// ===== rtl/cot_qmac.sv =====
// Shared multiply-accumulate unit with round-half-up and saturation.
module cot_qmac #(
  parameter int QW = cot_pkg::QUAT_WIDTH
) (
  input  logic                 clk_i,
  input  cot_pkg::mac_ctrl_t   ctrl_i,
  input  logic signed [QW:0]   a_i,
  input  logic signed [QW-1:0] b_i,
  output logic signed [QW-1:0] res_o
);
  localparam int PW = 2*QW+1;
  localparam int AW = 2*QW+4;
  localparam int F  = QW-2;
  localparam logic signed [AW-1:0] HALF = AW'(1) <<< (F-1);
  localparam logic signed [AW-1:0] QMAX = (AW'(1) <<< (QW-1)) - AW'(1);
  localparam logic signed [AW-1:0] QMIN = -(AW'(1) <<< (QW-1));

  logic signed [PW-1:0] prod;
  logic signed [AW-1:0] term, acc_in, sum, rnd;
  logic signed [AW-1:0] acc_q;

  assign prod   = a_i * b_i;
  assign term   = ctrl_i.neg ? -AW'(prod) : AW'(prod);
  assign acc_in = ctrl_i.clr ? '0 : acc_q;
  assign sum    = acc_in + term;
  assign rnd    = (sum + HALF) >>> F;

  always_comb begin
    priority if (rnd > QMAX) begin
      res_o = QMAX[QW-1:0];
    end else if (rnd < QMIN) begin
      res_o = QMIN[QW-1:0];
    end else begin
      res_o = rnd[QW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      acc_q <= sum;
    end
  end
endmodule

// ===== rtl/clutched_orientation_tracker.sv =====
// Top level of the two-hand clutched orientation tracker.
// Usage:
//   frame_i carries one controller frame per transaction: two button levels,
//   a wrapping millisecond stamp and the physical quaternion (signed Q1.14).
//   pose_o returns one transaction per frame with rest/aiming flags and the
//   virtual quaternion of each hand. dtap_we_i/dtap_wdata_i write the
//   double-tap window in ms; write only while the block is idle.
// Sequencing:
//   Each pressed hand takes a delta and a held Hamilton product; one 17x16
//   multiply-accumulate unit does all 16 terms of each product in turn.
//   frame_i.ready is high only while idle.
// Reset:
//   Both hands at identity pose and at rest, window 300 ms, no frame pending.
// Stall:
//   A result holds on pose_o until taken; no new frame enters meanwhile.
module clutched_orientation_tracker #(
  parameter int QW = cot_pkg::QUAT_WIDTH,
  parameter int SW = cot_pkg::STAMP_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           dtap_we_i,
  input  logic [cot_pkg::WIN_WIDTH-1:0]  dtap_wdata_i,
  cot_frame_if.sink                      frame_i,
  cot_pose_if.source                     pose_o
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PREP  = 5'b00010,
    S_DELTA = 5'b00100,
    S_HELD  = 5'b01000,
    S_OUT   = 5'b10000
  } state_e;

  localparam logic signed [QW-1:0] ONE = QW'(1) <<< (QW-2);

  state_e state_q, state_d;
  logic   h_q;
  logic [3:0] cnt_q;
  logic [cot_pkg::WIN_WIDTH-1:0] win_q;

  logic                 press_q [2];
  logic [SW-1:0]        now_q;
  logic signed [QW-1:0] phys_q  [4];
  logic signed [QW-1:0] delta_q [4];
  logic signed [QW-1:0] held_q  [2][4];
  logic signed [QW-1:0] base_q  [2][4];
  logic signed [QW-1:0] zero_q  [2][4];
  logic                 rest_q  [2];
  logic                 was_q   [2];
  logic [SW-1:0]        last_q  [2];
  logic [SW-1:0]        prev_q  [2];
  logic                 lastv_q [2];
  logic                 prevv_q [2];

  logic [1:0] ci, ck, bi;
  logic       pr, rise, fall, dtap;
  logic [SW-1:0] hold, gap, win_ext;
  logic signed [QW:0]   a_op;
  logic signed [QW-1:0] b_op, mac_res;
  cot_pkg::mac_ctrl_t   mac_ctrl;

  assign ci = cnt_q[3:2];
  assign ck = cnt_q[1:0];
  assign bi = ci ^ ck;

  assign pr      = press_q[h_q];
  assign rise    = pr && !was_q[h_q];
  assign fall    = !pr && was_q[h_q];
  assign hold    = now_q - last_q[h_q];
  assign gap     = last_q[h_q] - prev_q[h_q];
  assign win_ext = SW'(win_q);
  assign dtap    = fall && (hold < win_ext) && prevv_q[h_q] && (gap != '0) && (gap < win_ext);

  always_comb begin
    logic signed [QW:0] zx;
    zx = {zero_q[h_q][ck][QW-1], zero_q[h_q][ck]};
    if (state_q == S_DELTA) begin
      a_op = (ck == 2'd0) ? zx : -zx;
      b_op = phys_q[bi];
    end else begin
      a_op = {base_q[h_q][ck][QW-1], base_q[h_q][ck]};
      b_op = delta_q[bi];
    end
  end

  assign mac_ctrl.en  = (state_q == S_DELTA) || (state_q == S_HELD);
  assign mac_ctrl.clr = (ck == 2'd0);
  assign mac_ctrl.neg = cot_pkg::term_neg(ci, ck);

  cot_qmac #(.QW(QW)) u_qmac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .a_i    (a_op),
    .b_i    (b_op),
    .res_o  (mac_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (frame_i.valid) state_d = S_PREP;
      S_PREP:  begin
        if (pr) state_d = S_DELTA;
        else if (h_q) state_d = S_OUT;
      end
      S_DELTA: if (cnt_q == 4'hF) state_d = S_HELD;
      S_HELD:  if (cnt_q == 4'hF) state_d = h_q ? S_OUT : S_PREP;
      S_OUT:   if (pose_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      h_q     <= 1'b0;
      cnt_q   <= '0;
      win_q   <= cot_pkg::WIN_RESET;
      for (int h = 0; h < 2; h++) begin
        held_q[h][0] <= ONE;
        held_q[h][1] <= '0;
        held_q[h][2] <= '0;
        held_q[h][3] <= '0;
        rest_q[h]    <= 1'b1;
        was_q[h]     <= 1'b0;
        last_q[h]    <= '0;
        prev_q[h]    <= '0;
        lastv_q[h]   <= 1'b0;
        prevv_q[h]   <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      if (dtap_we_i) win_q <= dtap_wdata_i;
      unique case (state_q)
        S_IDLE: begin
          h_q   <= 1'b0;
          cnt_q <= '0;
        end
        S_PREP: begin
          cnt_q <= '0;
          if (!pr) h_q <= 1'b1;
          if (rise) begin
            prev_q[h_q]  <= last_q[h_q];
            prevv_q[h_q] <= lastv_q[h_q];
            last_q[h_q]  <= now_q;
            lastv_q[h_q] <= 1'b1;
          end
          if (pr) rest_q[h_q] <= 1'b0;
          // double tap only fires on release, so it never meets a press
          if (dtap) begin
            prevv_q[h_q]   <= 1'b0;
            rest_q[h_q]    <= 1'b1;
            held_q[h_q][0] <= ONE;
            held_q[h_q][1] <= '0;
            held_q[h_q][2] <= '0;
            held_q[h_q][3] <= '0;
          end
          was_q[h_q] <= pr;
        end
        S_DELTA: cnt_q <= cnt_q + 4'd1;
        S_HELD: begin
          cnt_q <= cnt_q + 4'd1;
          if (ck == 2'd3) held_q[h_q][ci] <= mac_res;
          if (cnt_q == 4'hF) h_q <= 1'b1;
        end
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && frame_i.valid) begin
      press_q[0] <= frame_i.left_pressed;
      press_q[1] <= frame_i.right_pressed;
      now_q      <= frame_i.time_ms;
      phys_q[0]  <= frame_i.phys_w;
      phys_q[1]  <= frame_i.phys_x;
      phys_q[2]  <= frame_i.phys_y;
      phys_q[3]  <= frame_i.phys_z;
    end
    // latch base and zero on a press edge
    if (state_q == S_PREP && rise) begin
      for (int j = 0; j < 4; j++) begin
        base_q[h_q][j] <= held_q[h_q][j];
        zero_q[h_q][j] <= phys_q[j];
      end
    end
    if (state_q == S_DELTA && ck == 2'd3) delta_q[ci] <= mac_res;
  end

  assign frame_i.ready = (state_q == S_IDLE);

  assign pose_o.valid         = (state_q == S_OUT);
  assign pose_o.left_at_rest  = rest_q[0];
  assign pose_o.left_aiming   = press_q[0];
  assign pose_o.left_w        = held_q[0][0];
  assign pose_o.left_x        = held_q[0][1];
  assign pose_o.left_y        = held_q[0][2];
  assign pose_o.left_z        = held_q[0][3];
  assign pose_o.right_at_rest = rest_q[1];
  assign pose_o.right_aiming  = press_q[1];
  assign pose_o.right_w       = held_q[1][0];
  assign pose_o.right_x       = held_q[1][1];
  assign pose_o.right_y       = held_q[1][2];
  assign pose_o.right_z       = held_q[1][3];

`ifndef SYNTHESIS
  a_accept_prep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_i.valid && frame_i.ready |=> state_q == S_PREP)
    else $error("frame transaction did not start the sequencer");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pose_o.valid && pose_o.ready |=> frame_i.ready)
    else $error("block not idle after result transaction");
  a_delta_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DELTA && cnt_q == 4'hF |=> state_q == S_HELD && cnt_q == 4'h0)
    else $error("delta product not followed by held product");
`endif
endmodule
